>>> rtl/core/rhp_pkg.sv
// shared types, constants and divider step for the rgb to hsv pixel unit
`timescale 1ns / 1ps

package rhp_pkg;

   // channel and datapath widths
   localparam int CHAN_WIDTH     = 8;
   localparam int QUO_WIDTH      = 8;
   localparam int QUO_IDX_WIDTH  = $clog2(QUO_WIDTH);
   localparam int NUM_WIDTH      = 11;
   localparam int SIGNED_WIDTH   = 12;
   localparam int REM_WIDTH      = 20;
   localparam int DIVR_WIDTH     = 12;
   localparam int BITS_PER_STAGE = 2;
   localparam int DIV_STAGES     = QUO_WIDTH / BITS_PER_STAGE;

   // twice the full scale, six sectors per turn, twice six for the hue denominator
   localparam int SCALE2        = 510;
   localparam int SECTOR_SPAN   = 6;
   localparam int HUE_DEN_SCALE = 12;

   // hue sector codes
   localparam logic [1:0] SECTOR_RED   = 2'd0;
   localparam logic [1:0] SECTOR_GREEN = 2'd1;
   localparam logic [1:0] SECTOR_BLUE  = 2'd2;

   // one restoring division in flight
   typedef struct packed {
      logic [REM_WIDTH-1:0]  rem;
      logic [DIVR_WIDTH-1:0] divisor;
      logic [QUO_WIDTH-1:0]  quo;
   } div_lane_type;

   // what travels down the divider pipeline
   typedef struct packed {
      div_lane_type          hue;
      div_lane_type          sat;
      logic [CHAN_WIDTH-1:0] bright;
   } div_item_type;

   // one quotient bit of a restoring divide
   function automatic div_lane_type div_step(div_lane_type lane,
                                             logic [QUO_IDX_WIDTH-1:0] bit_pos);
      logic [REM_WIDTH-1:0] trial;
      div_lane_type         res;
      trial = {{(REM_WIDTH-DIVR_WIDTH){1'b0}}, lane.divisor} << bit_pos;
      res   = lane;
      if (lane.rem >= trial) begin
         res.rem          = lane.rem - trial;
         res.quo[bit_pos] = 1'b1;
      end
      return res;
   endfunction

endpackage

>>> rtl/core/rhp_req_if.sv
// pixel request channel: valid, ready and one rgb pixel
`timescale 1ns / 1ps

interface rhp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

>>> rtl/core/rhp_rsp_if.sv
// pixel response channel: valid, ready and one hsv pixel
`timescale 1ns / 1ps

interface rhp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] hue;
   logic [7:0] saturation;
   logic [7:0] brightness;

   modport source (output valid, output hue, output saturation, output brightness,
                   input ready);
   modport sink   (input valid, input hue, input saturation, input brightness,
                   output ready);
endinterface

>>> rtl/core/rhp_front.sv
// front end: channel max/min and sector, then hue and saturation dividends
`timescale 1ns / 1ps

module rhp_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [7:0]           red,
   input  logic [7:0]           green,
   input  logic [7:0]           blue,
   output logic                 out_valid,
   input  logic                 out_ready,
   output rhp_pkg::div_item_type out_item
);
   import rhp_pkg::*;

   typedef struct packed {
      logic [CHAN_WIDTH-1:0] mx;
      logic [CHAN_WIDTH-1:0] mn;
      logic [1:0]            sector;
      logic [CHAN_WIDTH-1:0] r;
      logic [CHAN_WIDTH-1:0] g;
      logic [CHAN_WIDTH-1:0] b;
   } extrema_type;

   extrema_type  ext_ff, ext_in;
   logic         ext_valid_ff;
   logic         ext_ready;
   div_item_type div_ff, div_in;
   logic         div_valid_ff;
   logic         div_ready;

   logic [CHAN_WIDTH-1:0]   delta;
   logic [NUM_WIDTH-1:0]    delta6;
   logic [SIGNED_WIDTH-1:0] num_s;
   logic [NUM_WIDTH-1:0]    num;

   // stage ready chain
   assign div_ready = !div_valid_ff || out_ready;
   assign ext_ready = !ext_valid_ff || div_ready;
   assign in_ready  = ext_ready;

   // stage 1: max, min, sector with red then green winning ties
   always_comb begin
      ext_in.r = red;
      ext_in.g = green;
      ext_in.b = blue;
      if (red >= green && red >= blue) begin
         ext_in.sector = SECTOR_RED;
         ext_in.mx     = red;
      end else if (green >= blue) begin
         ext_in.sector = SECTOR_GREEN;
         ext_in.mx     = green;
      end else begin
         ext_in.sector = SECTOR_BLUE;
         ext_in.mx     = blue;
      end
      ext_in.mn = red;
      if (green < ext_in.mn) ext_in.mn = green;
      if (blue < ext_in.mn)  ext_in.mn = blue;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ext_valid_ff <= 1'b0;
      end else if (ext_ready) begin
         ext_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ext_ready && in_valid) begin
         ext_ff <= ext_in;
      end
   end

   // stage 2: hue numerator within the turn, wrapped once when negative
   assign delta  = ext_ff.mx - ext_ff.mn;
   assign delta6 = NUM_WIDTH'(delta) * NUM_WIDTH'(SECTOR_SPAN);

   always_comb begin
      case (ext_ff.sector)
         SECTOR_RED: begin
            num_s = SIGNED_WIDTH'(ext_ff.g) - SIGNED_WIDTH'(ext_ff.b);
            if (num_s[SIGNED_WIDTH-1]) begin
               num_s = num_s + SIGNED_WIDTH'(delta6);
            end
         end
         SECTOR_GREEN: begin
            num_s = SIGNED_WIDTH'({delta, 1'b0}) + SIGNED_WIDTH'(ext_ff.b)
                    - SIGNED_WIDTH'(ext_ff.r);
         end
         SECTOR_BLUE: begin
            num_s = SIGNED_WIDTH'({delta, 2'b00}) + SIGNED_WIDTH'(ext_ff.r)
                    - SIGNED_WIDTH'(ext_ff.g);
         end
         default: begin
            num_s = '0;
         end
      endcase
      num = num_s[NUM_WIDTH-1:0];
   end

   // dividends and divisors; a zero divisor becomes one over a zero dividend
   always_comb begin
      div_in.hue.rem     = REM_WIDTH'(num) * REM_WIDTH'(SCALE2) + REM_WIDTH'(delta6);
      div_in.hue.divisor = (delta == '0) ? DIVR_WIDTH'(1)
                           : DIVR_WIDTH'(delta) * DIVR_WIDTH'(HUE_DEN_SCALE);
      div_in.hue.quo     = '0;
      div_in.sat.rem     = REM_WIDTH'(delta) * REM_WIDTH'(SCALE2) + REM_WIDTH'(ext_ff.mx);
      div_in.sat.divisor = (ext_ff.mx == '0) ? DIVR_WIDTH'(1)
                           : DIVR_WIDTH'({ext_ff.mx, 1'b0});
      div_in.sat.quo     = '0;
      div_in.bright      = ext_ff.mx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_valid_ff <= 1'b0;
      end else if (div_ready) begin
         div_valid_ff <= ext_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (div_ready && ext_valid_ff) begin
         div_ff <= div_in;
      end
   end

   assign out_valid = div_valid_ff;
   assign out_item  = div_ff;

endmodule

>>> rtl/core/rhp_divide.sv
// pipelined restoring divider for hue and saturation in lockstep
`timescale 1ns / 1ps

module rhp_divide (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  rhp_pkg::div_item_type in_item,
   output logic                  out_valid,
   input  logic                  out_ready,
   output rhp_pkg::div_item_type out_item
);
   import rhp_pkg::*;

   div_item_type          stage_ff [DIV_STAGES];
   div_item_type          stage_in [DIV_STAGES];
   logic [DIV_STAGES-1:0] valid_ff;
   logic [DIV_STAGES-1:0] src_valid;
   logic [DIV_STAGES-1:0] stage_ready;

   genvar k;
   generate
      for (k = 0; k < DIV_STAGES; k++) begin : g_stage
         div_item_type src;

         // source of this stage and ready from downstream
         if (k == 0) begin : g_first
            assign src          = in_item;
            assign src_valid[k] = in_valid;
         end else begin : g_next
            assign src          = stage_ff[k-1];
            assign src_valid[k] = valid_ff[k-1];
         end

         if (k == DIV_STAGES-1) begin : g_last
            assign stage_ready[k] = !valid_ff[k] || out_ready;
         end else begin : g_mid
            assign stage_ready[k] = !valid_ff[k] || stage_ready[k+1];
         end

         // BITS_PER_STAGE quotient bits per stage, most significant first
         always_comb begin
            stage_in[k] = src;
            for (int j = 0; j < BITS_PER_STAGE; j++) begin
               stage_in[k].hue = div_step(stage_in[k].hue,
                  QUO_IDX_WIDTH'(QUO_WIDTH - 1 - BITS_PER_STAGE * k - j));
               stage_in[k].sat = div_step(stage_in[k].sat,
                  QUO_IDX_WIDTH'(QUO_WIDTH - 1 - BITS_PER_STAGE * k - j));
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[k] <= 1'b0;
            end else if (stage_ready[k]) begin
               valid_ff[k] <= src_valid[k];
            end
         end

         always_ff @(posedge clock) begin
            if (stage_ready[k] && src_valid[k]) begin
               stage_ff[k] <= stage_in[k];
            end
         end
      end
   endgenerate

   assign in_ready  = stage_ready[0];
   assign out_valid = valid_ff[DIV_STAGES-1];
   assign out_item  = stage_ff[DIV_STAGES-1];

endmodule

>>> rtl/core/rgb_to_hsv_pixel_unit.sv
// top level of the rgb to hsv pixel converter
// Converts one 8-bit RGB pixel per clock into 8-bit hue, saturation and
// brightness (value). Brightness is the largest channel, saturation is
// round(255*delta/max), hue is the angle as a fraction of a turn scaled to
// 0..255, all rounded half up; black and grey pixels give hue 0. The unit is
// a six-stage pipeline: two front stages find max/min and form the dividends,
// then four divider stages each retire two quotient bits of the hue and
// saturation divides. Each pixel moves through the extrema, dividend and
// divider registers in order, the last driving the response; with the
// response side ready a new pixel is accepted every cycle.
// Back-pressure stalls only the stages that hold data, so bubbles still fill.
`timescale 1ns / 1ps

module rgb_to_hsv_pixel_unit (
   input logic      clock,
   input logic      reset,
   rhp_req_if.sink  req_chan,
   rhp_rsp_if.source rsp_chan
);
   import rhp_pkg::*;

   logic         mid_valid;
   logic         mid_ready;
   div_item_type mid_item;
   logic         fin_valid;
   div_item_type fin_item;

   // extrema and dividend stages
   rhp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .red       (req_chan.red),
      .green     (req_chan.green),
      .blue      (req_chan.blue),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .out_item  (mid_item)
   );

   // divider stages, last one is the output register
   rhp_divide u_divide (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .in_item   (mid_item),
      .out_valid (fin_valid),
      .out_ready (rsp_chan.ready),
      .out_item  (fin_item)
   );

   // both quotients stay below 256 by construction
   assign rsp_chan.valid      = fin_valid;
   assign rsp_chan.hue        = fin_item.hue.quo;
   assign rsp_chan.saturation = fin_item.sat.quo;
   assign rsp_chan.brightness = fin_item.bright;

endmodule

>>> rtl/core/rhp_checker.sv
// port-level assertions for the rgb to hsv pixel unit and their bind
`timescale 1ns / 1ps

module rhp_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_hue,
   input logic [7:0] rsp_saturation,
   input logic [7:0] rsp_brightness
);

   // a pending result is held until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   // a stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_hue) && $stable(rsp_saturation)
                                  && $stable(rsp_brightness))
      else $error("rsp payload changed while stalled");

   // input back-pressure only comes from a stalled output
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("req not ready without output stall");

   // black pixel has no hue and no saturation
   a_black: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_brightness == 8'd0 |-> rsp_saturation == 8'd0 && rsp_hue == 8'd0)
      else $error("black pixel with nonzero hue or saturation");

endmodule

bind rgb_to_hsv_pixel_unit rhp_checker u_rhp_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_hue        (rsp_chan.hue),
   .rsp_saturation (rsp_chan.saturation),
   .rsp_brightness (rsp_chan.brightness)
);
